@@ rtl/srf_pkg.sv @@
// Shared types and constants for the stream find-and-replace block.
// Used by srf_ctrl, srf_datapath and stream_find_and_replace; no dependencies.
package srf_pkg;

    localparam int PATTERN_MAX = 8;
    localparam int REPL_MAX    = 8;
    // Pending bytes plus the word just taken in.
    localparam int BUF_DEPTH   = PATTERN_MAX + 1;
    localparam int CNT_W       = $clog2(BUF_DEPTH + 1);
    localparam int RIDX_W      = $clog2(REPL_MAX);
    localparam int LEN_W       = 4;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [7:0] LINE_BARRIER = 8'h0A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } cfg_idx_t;

    // Controller to datapath.
    typedef struct packed {
        logic append;     // take the input word into the buffer tail
        logic drop;       // emit the buffer head and shift
        logic repl_emit;  // emit the current replacement byte
        logic clear;      // empty the buffer after a replacement
        logic last;       // emitted word closes the run
    } srf_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic prefix_ok;          // buffer is a prefix of the pattern
        logic shifted_prefix_ok;  // buffer without its head is a prefix
        logic cm1_eq_plen;        // count - 1 equals pattern length
        logic count_eq_plen;
        logic repl_at_end;
        logic newline;
        logic stream_end;
        logic can_emit;
    } srf_status_t;

endpackage

@@ rtl/srf_ctrl.sv @@
// Sequencer for the stream find-and-replace block.
// Depends on srf_pkg; drives srf_datapath through srf_cmd_t.
module srf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  srf_pkg::srf_status_t status,
    output srf_pkg::srf_cmd_t    cmd
);
    import srf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESCAN,
        ST_REPL,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.append = in_valid;
                if (in_valid)
                begin
                    state_next = ST_RESCAN;
                end
            end
            ST_RESCAN:
            begin
                if (status.newline)
                begin
                    state_next = ST_FLUSH;
                end
                else if (!status.count_zero && !status.prefix_ok)
                begin
                    // Naive rescan: drop the head; this word closes the run only
                    // if nothing else can follow it.
                    if (status.can_emit)
                    begin
                        cmd.drop = 1'b1;
                        cmd.last = status.shifted_prefix_ok && !status.cm1_eq_plen
                                   && !(status.stream_end && !status.count_one);
                    end
                end
                else if (status.count_eq_plen)
                begin
                    state_next = ST_REPL;
                end
                else if (status.stream_end && !status.count_zero)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REPL:
            begin
                if (status.can_emit)
                begin
                    cmd.repl_emit = 1'b1;
                    cmd.last      = status.repl_at_end;
                    if (status.repl_at_end)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (status.can_emit)
                begin
                    cmd.drop = 1'b1;
                    cmd.last = status.count_one;
                    if (status.count_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/srf_datapath.sv @@
// Datapath for the stream find-and-replace block: config registers, pending
// byte shift line, prefix compare and output register. Depends on srf_pkg.
module srf_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [srf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srf_pkg::CFG_W-1:0]     cfg_data,
    input  logic [7:0]                    in_byte,
    input  logic                          in_end,
    input  srf_pkg::srf_cmd_t             cmd,
    output srf_pkg::srf_status_t          status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_byte,
    output logic                          out_last
);
    import srf_pkg::*;

    logic [CFG_W-1:0]  pat_bytes_reg;
    logic [LEN_W-1:0]  pat_len_reg;
    logic [CFG_W-1:0]  rep_bytes_reg;
    logic [LEN_W-1:0]  rep_len_reg;

    logic [7:0]        buf_reg [BUF_DEPTH];
    logic [7:0]        buf_next [BUF_DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [RIDX_W-1:0] ridx_reg;
    logic [RIDX_W-1:0] ridx_next;
    logic              newline_reg;
    logic              end_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_byte_reg;
    logic [7:0]        out_byte_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic [CNT_W-1:0]  plen;
    logic [CNT_W-1:0]  rlen;
    logic [CNT_W-1:0]  count_m1;
    logic              match_all;
    logic              match_shift;
    logic              can_emit;
    logic [7:0]        rep_byte;

    // Clamp lengths to 1..max.
    always_comb
    begin
        if (pat_len_reg == '0)
            plen = CNT_W'(1);
        else if (CNT_W'(pat_len_reg) > CNT_W'(PATTERN_MAX))
            plen = CNT_W'(PATTERN_MAX);
        else
            plen = CNT_W'(pat_len_reg);

        if (rep_len_reg == '0)
            rlen = CNT_W'(1);
        else if (CNT_W'(rep_len_reg) > CNT_W'(REPL_MAX))
            rlen = CNT_W'(REPL_MAX);
        else
            rlen = CNT_W'(rep_len_reg);
    end

    assign count_m1 = count_reg - CNT_W'(1);

    // Byte compares against the pattern, one per position, masked by count.
    always_comb
    begin
        match_all   = 1'b1;
        match_shift = 1'b1;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (CNT_W'(k) < count_reg && buf_reg[k] != pat_bytes_reg[8*k +: 8])
                match_all = 1'b0;
            if (CNT_W'(k + 1) < count_reg && buf_reg[k+1] != pat_bytes_reg[8*k +: 8])
                match_shift = 1'b0;
        end
    end

    assign can_emit = !out_valid_reg || out_ready;
    assign rep_byte = rep_bytes_reg[8*ridx_reg +: 8];

    always_comb
    begin
        status.count_zero        = (count_reg == '0);
        status.count_one         = (count_reg == CNT_W'(1));
        status.prefix_ok         = (count_reg <= plen) && match_all;
        status.shifted_prefix_ok = (count_m1 <= plen) && match_shift;
        status.cm1_eq_plen       = (count_m1 == plen);
        status.count_eq_plen     = (count_reg == plen);
        status.repl_at_end       = (CNT_W'(ridx_reg) + CNT_W'(1) == rlen);
        status.newline           = newline_reg;
        status.stream_end        = end_reg;
        status.can_emit          = can_emit;
    end

    // Pending buffer: append at the tail, shift out at the head.
    always_comb
    begin
        for (int k = 0; k < BUF_DEPTH; k++)
        begin
            buf_next[k] = buf_reg[k];
            if (cmd.append && count_reg == CNT_W'(k))
                buf_next[k] = in_byte;
        end
        if (cmd.drop)
        begin
            for (int k = 0; k < BUF_DEPTH - 1; k++)
                buf_next[k] = buf_reg[k+1];
        end

        count_next = count_reg;
        if (cmd.append)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.clear)
            count_next = '0;
        else if (cmd.drop)
            count_next = count_m1;

        ridx_next = ridx_reg;
        if (cmd.clear)
            ridx_next = '0;
        else if (cmd.repl_emit)
            ridx_next = ridx_reg + RIDX_W'(1);

        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (cmd.drop || cmd.repl_emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cmd.drop ? buf_reg[0] : rep_byte;
            out_last_next  = cmd.last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= LEN_W'(1);
            rep_bytes_reg <= '0;
            rep_len_reg   <= LEN_W'(1);
            count_reg     <= '0;
            ridx_reg      <= '0;
            newline_reg   <= 1'b0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_PATTERN_BYTES:      pat_bytes_reg <= cfg_data;
                    CFG_PATTERN_LENGTH:     pat_len_reg   <= cfg_data[LEN_W-1:0];
                    CFG_REPLACEMENT_BYTES:  rep_bytes_reg <= cfg_data;
                    CFG_REPLACEMENT_LENGTH: rep_len_reg   <= cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            count_reg     <= count_next;
            ridx_reg      <= ridx_next;
            out_valid_reg <= out_valid_next;
            if (cmd.append)
            begin
                newline_reg <= (in_byte == LINE_BARRIER);
                end_reg     <= in_end;
            end
        end
    end

    // Payload only: no reset.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < BUF_DEPTH; k++)
            buf_reg[k] <= buf_next[k];
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

@@ rtl/stream_find_and_replace.sv @@
// Top level of the stream find-and-replace block.
// Depends on srf_pkg, srf_ctrl and srf_datapath.
//
//  channel   | signals                                   | word contents
//  ----------+-------------------------------------------+------------------------------
//  s_axis    | tvalid, tready, tdata[7:0], tlast         | in_byte; tlast = stream_end
//  m_axis    | tvalid, tready, tdata[7:0], tlast         | out_byte; tlast = run_last
//  cfg       | cfg_we, cfg_index[1:0], cfg_data[63:0]    | register write, no read-back
//
// An input word is accepted in the idle state and checked against the pattern in
// the rescan state that follows. Each emitted output word (drop, replacement
// byte or flush) goes through the single output register; a full match emits
// the replacement bytes in place of the pattern. Input is accepted only while
// the sequencer is idle; a full output register with tready low holds the
// sequencer in place.
// Reset empties the pending buffer and loads pattern and replacement length 1.
module stream_find_and_replace (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port
    input  logic                          cfg_we,
    input  logic [srf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srf_pkg::CFG_W-1:0]     cfg_data,
    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] in_byte
    input  logic                          s_axis_tlast,   // stream_end
    // Output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [7:0] out_byte
    output logic                          m_axis_tlast    // run_last
);
    import srf_pkg::*;

    srf_cmd_t    cmd;
    srf_status_t status;

    // Sequence append, rescan, replacement and flush steps.
    srf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold pending bytes, compare against the pattern, register the output word.
    srf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_byte   (s_axis_tdata),
        .in_end    (s_axis_tlast),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
